[hw/rtl/hbp_pkg.sv]
// Shared types and constants for the Huffman bit packer.
package hbp_pkg;

  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int CODE_W    = 32;
  localparam int ENTRY_W   = LEN_W + CODE_W;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  localparam int ACC_W     = PEND_W + CODE_W;
  localparam int TOTAL_W   = 6;
  localparam int BYTE_W    = 8;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMBINE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic tbl_wr;
    logic tbl_rd;
    logic combine;
    logic flush_load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic has_byte;
  } status_t;

endpackage

[hw/rtl/hbp_if.sv]
// Valid/ready channel interfaces for input items and packed output bytes.
interface hbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  symbol;
  logic [5:0]  code_length;
  logic [31:0] code_bits;

  modport source (output valid, output op, output symbol, output code_length,
                  output code_bits, input ready);
  modport sink   (input valid, input op, input symbol, input code_length,
                  input code_bits, output ready);
endinterface

interface hbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last;

  modport source (output valid, output packed_byte, output last, input ready);
  modport sink   (input valid, input packed_byte, input last, output ready);
endinterface

[hw/rtl/hbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/hbp_ctrl.sv]
// Controller state machine sequencing table access, bit merging and byte output.
module hbp_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [hbp_pkg::OP_W-1:0]  in_op,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  hbp_pkg::status_t          status,
  output hbp_pkg::cmd_t             cmd
);
  import hbp_pkg::*;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_ENCODE && status.sym_ok) begin
            state_nxt = ST_COMBINE;
          end else if (in_op == OP_FLUSH) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_COMBINE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.has_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.tbl_wr     = in_acc && (in_op == OP_LOAD) && status.sym_ok;
        cmd.tbl_rd     = in_acc && (in_op == OP_ENCODE) && status.sym_ok;
        cmd.flush_load = in_acc && (in_op == OP_FLUSH);
      end
      ST_COMBINE: begin
        cmd.combine = 1'b1;
      end
      ST_EMIT: begin
        out_valid  = status.has_byte;
        cmd.step   = status.has_byte && out_ready;
        cmd.finish = !status.has_byte;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/hbp_datapath.sv]
// Datapath: code table, pending bit buffer, merge accumulator and byte extraction.
module hbp_datapath #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hbp_pkg::SYM_W-1:0]    symbol,
  input  logic [hbp_pkg::LEN_W-1:0]    code_length,
  input  logic [hbp_pkg::CODE_W-1:0]   code_bits,
  input  hbp_pkg::cmd_t                cmd,
  output hbp_pkg::status_t             status,
  output logic [hbp_pkg::BYTE_W-1:0]   packed_byte,
  output logic                         last
);
  import hbp_pkg::*;

  localparam int ADDR_W  = $clog2(NUM_SYMBOLS);
  localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

  logic [PEND_W-1:0]  pend_bits_r, pend_bits_nxt;
  logic [CNT_W-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic [LEN_W-1:0]   wr_len;
  logic [CODE_W:0]    wr_mask_wide;
  logic [CODE_W-1:0]  wr_code;
  logic [ENTRY_W-1:0] rd_entry;
  logic [LEN_W-1:0]   rd_len;
  logic [TOTAL_W-1:0] shift_amt;
  logic [ACC_W-1:0]   shifted;
  logic [BYTE_W:0]    flush_wide;

  assign status.sym_ok = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));

  // Lengths beyond the supported maximum saturate; code bits above the length are dropped.
  assign wr_len = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;
  assign wr_mask_wide = ((CODE_W + 1)'(1) << wr_len) - (CODE_W + 1)'(1);
  assign wr_code = code_bits & wr_mask_wide[CODE_W-1:0];

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_code_table (
    .clk   (clk),
    .we    (cmd.tbl_wr),
    .waddr (symbol[ADDR_W-1:0]),
    .wdata ({wr_len, wr_code}),
    .re    (cmd.tbl_rd),
    .raddr (symbol[ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  assign rd_len = rd_entry[ENTRY_W-1:CODE_W];

  assign status.has_byte = (total_r >= TOTAL_W'(BYTE_W));

  assign shift_amt   = total_r - TOTAL_W'(BYTE_W);
  assign shifted     = acc_r >> shift_amt;
  assign packed_byte = shifted[BYTE_W-1:0];
  assign last        = (total_r < TOTAL_W'(2 * BYTE_W));

  // A flush pads the pending bits on the right to form one full byte.
  assign flush_wide = {2'b00, pend_bits_r} << (4'(BYTE_W) - {1'b0, pend_cnt_r});

  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (cmd.combine) begin
      acc_nxt   = ({{CODE_W{1'b0}}, pend_bits_r} << rd_len)
                | {{PEND_W{1'b0}}, rd_entry[CODE_W-1:0]};
      total_nxt = {{(TOTAL_W - CNT_W){1'b0}}, pend_cnt_r} + rd_len;
    end else if (cmd.flush_load) begin
      acc_nxt   = {{(ACC_W - BYTE_W){1'b0}}, flush_wide[BYTE_W-1:0]};
      total_nxt = TOTAL_W'(BYTE_W);
    end else if (cmd.step) begin
      total_nxt = total_r - TOTAL_W'(BYTE_W);
    end else if (cmd.finish) begin
      pend_cnt_nxt  = total_r[CNT_W-1:0];
      pend_bits_nxt = acc_r[PEND_W-1:0] & (7'h7F >> (3'd7 - total_r[CNT_W-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      total_r     <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

[hw/rtl/huffman_bit_packer_core.sv]
// Huffman bit packer top level: channel hookup of controller and datapath.
//
// in_if carries one item per handshake: op load writes a code table entry,
// op encode appends the code of a byte to the pending bits, op flush emits the
// pending bits padded with zeros (0x00 if none) and empties the buffer.
// out_if carries one packed byte per handshake, earliest code bit in bit 7, with
// last set on the final byte caused by an input item.
// Items are handled one at a time. A load, an unknown op or an encode of a
// symbol beyond the table finishes in the idle state. An encode reads the
// table in idle, merges the bits in the combine state, then emits its bytes
// (up to four) in the emit state and stores the leftover bits on leaving it.
// A flush loads the padded byte in idle, emits it and then clears the buffer.
// Reset clears the pending bits and the controller; the code table is not
// cleared, and each entry must be loaded before it is encoded.
// When the receiver holds out_if.ready low, the current byte stays on the
// port and no new input item is taken until all bytes are delivered.
module huffman_bit_packer_core #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  hbp_in_if.sink    in_if,
  hbp_out_if.source out_if
);
  import hbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  hbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hbp_datapath #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .symbol      (in_if.symbol),
    .code_length (in_if.code_length),
    .code_bits   (in_if.code_bits),
    .cmd         (cmd),
    .status      (status),
    .packed_byte (out_if.packed_byte),
    .last        (out_if.last)
  );

endmodule

[dv/huffman_bit_packer_core_tb.sv]
// Self-checking testbench for the Huffman bit packer: directed table, random items, byte checks.
`timescale 1ns / 1ps

module huffman_bit_packer_core_tb;
  import hbp_pkg::*;

  localparam int NUM_SYMBOLS = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int FROM_PREDICTOR = -1;
  localparam int RANDOM_ITEMS = 430;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } packed_out_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [SYM_W-1:0]         sym;
    logic [LEN_W-1:0]         len;
    logic [CODE_W-1:0]        code;
    int                       typed_n;
    logic [3:0][BYTE_W-1:0]   typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  hbp_in_if  in_if ();
  hbp_out_if out_if ();

  huffman_bit_packer_core #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: code table plus the leftover bits of the last encode.
  logic [LEN_W-1:0]  code_len_q [NUM_SYMBOLS];
  logic [CODE_W-1:0] code_val_q [NUM_SYMBOLS];
  logic [PEND_W-1:0] pend_bits = '0;
  logic [CNT_W-1:0]  pend_cnt = '0;
  bit                written [NUM_SYMBOLS];
  logic [SYM_W-1:0]  written_syms [$];

  packed_out_t expected_bytes [$];
  stim_row_t   stim_rows [$];
  packed_out_t got_byte;
  int          errors = 0;
  int          rx_bytes = 0;
  bit          long_hold_done = 1'b0;
  int          idle_cycles = 0;

  task automatic predict_packed_bytes(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                      input logic [LEN_W-1:0] len,
                                      input logic [CODE_W-1:0] code, output int n,
                                      output logic [3:0][BYTE_W-1:0] bytes);
    int unsigned l;
    int unsigned total;
    logic [CODE_W-1:0] c;
    logic [63:0] acc;
    logic [63:0] shifted;
    logic [BYTE_W-1:0] tail;
    n = 0;
    bytes = '0;
    case (op)
      OP_LOAD: begin
        if (int'(sym) < NUM_SYMBOLS) begin
          l = (len > LEN_CAP) ? LEN_CAP : len;
          code_len_q[sym] = l[LEN_W-1:0];
          code_val_q[sym] = (l >= CODE_W) ? code : (code & ((32'd1 << l) - 32'd1));
        end
      end
      OP_ENCODE: begin
        l = 0;
        c = '0;
        if (int'(sym) < NUM_SYMBOLS) begin
          l = code_len_q[sym];
          c = code_val_q[sym];
        end
        acc = (64'(pend_bits) << l) | 64'(c);
        total = pend_cnt + l;
        while (total >= 8 && n < 4) begin
          shifted = acc >> (total - 8);
          bytes[n] = shifted[BYTE_W-1:0];
          total -= 8;
          n++;
        end
        pend_cnt = total[CNT_W-1:0];
        acc = acc & ((64'd1 << pend_cnt) - 64'd1);
        pend_bits = acc[PEND_W-1:0];
      end
      OP_FLUSH: begin
        tail = {1'b0, pend_bits};
        bytes[0] = (pend_cnt == 0) ? 8'h00 : BYTE_W'(tail << (8 - pend_cnt));
        n = 1;
        pend_bits = '0;
        pend_cnt = '0;
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                         input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                         input int typed_n, input logic [3:0][BYTE_W-1:0] typed);
    stim_row_t row;
    row.op = op;
    row.sym = sym;
    row.len = len;
    row.code = code;
    row.typed_n = typed_n;
    row.typed = typed;
    stim_rows.push_back(row);
  endtask

  // Offers one item, waits for its handshake, then queues the bytes it must cause.
  task automatic apply_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                            input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                            input int typed_n, input logic [3:0][BYTE_W-1:0] typed,
                            input bit quiet);
    int gap;
    int n;
    logic [3:0][BYTE_W-1:0] bytes;
    packed_out_t e;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.symbol <= sym;
    in_if.code_length <= len;
    in_if.code_bits <= code;
    do @(posedge clk); while (!in_if.ready);
    predict_packed_bytes(op, sym, len, code, n, bytes);
    if (op == OP_LOAD && !written[sym]) begin
      written[sym] = 1'b1;
      written_syms.push_back(sym);
    end
    if (typed_n != FROM_PREDICTOR) begin
      n = typed_n;
      bytes = typed;
    end
    for (int k = 0; k < n; k++) begin
      e.value = bytes[k];
      e.last = (k == n - 1);
      expected_bytes.push_back(e);
    end
  endtask

  // Scoreboard: every delivered byte is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h last %0b", $time,
                 out_if.packed_byte, out_if.last);
        errors++;
      end else begin
        got_byte = expected_bytes.pop_front();
        if (got_byte.value !== out_if.packed_byte) begin
          $display("%0t: packed_byte mismatch: expected %02h, actual %02h", $time,
                   got_byte.value, out_if.packed_byte);
          errors++;
        end
        if (got_byte.last !== out_if.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                   got_byte.last, out_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("huffman_bit_packer_core_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls per byte, quiet stretches, and one long hold-off.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_bytes >= 60 && !long_hold_done) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else if (((rx_bytes / 48) % 3) == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      rx_bytes++;
    end
  end

  initial begin
    int r;
    bit quiet;
    logic [OP_W-1:0] op;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    logic [CODE_W-1:0] code;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= OP_LOAD;
    in_if.symbol <= '0;
    in_if.code_length <= '0;
    in_if.code_bits <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_row(OP_FLUSH,   8'd0,   6'd0,  32'h0,        1, 32'h00000000);
    add_row(OP_UNKNOWN, 8'd255, 6'd63, 32'hFFFFFFFF, 0, '0);
    // A zero-length code must append nothing.
    add_row(OP_LOAD,    8'd0,   6'd0,  32'hFFFFFFFF, 0, '0);
    add_row(OP_ENCODE,  8'd0,   6'd0,  32'h0,        0, '0);
    add_row(OP_LOAD,    8'd255, 6'd32, 32'hFFFFFFFF, 0, '0);
    add_row(OP_ENCODE,  8'd255, 6'd63, 32'hFFFFFFFF, 4, 32'hFFFFFFFF);
    // Length above the cap saturates; bits above the length are dropped.
    add_row(OP_LOAD,    8'd1,   6'd63, 32'h12345678, 0, '0);
    add_row(OP_LOAD,    8'd2,   6'd7,  32'hFFFFFF81, 0, '0);
    add_row(OP_ENCODE,  8'd2,   6'd0,  32'h0,        0, '0);
    // Seven bits pending plus a full 32-bit code gives the maximum of four bytes.
    add_row(OP_ENCODE,  8'd1,   6'd0,  32'h0,        FROM_PREDICTOR, '0);
    add_row(OP_FLUSH,   8'd0,   6'd0,  32'h0,        FROM_PREDICTOR, '0);
    add_row(OP_FLUSH,   8'd0,   6'd0,  32'h0,        1, 32'h00000000);
    add_row(OP_LOAD,    8'd3,   6'd1,  32'h1,        0, '0);
    for (int k = 0; k < 4; k++) add_row(OP_ENCODE, 8'd3, 6'd0, 32'h0, 0, '0);
    add_row(OP_FLUSH,   8'd0,   6'd0,  32'h0,        1, 32'h000000F0);
    add_row(OP_LOAD,    8'd128, 6'd33, 32'h0,        0, '0);
    add_row(OP_ENCODE,  8'd128, 6'd0,  32'h0,        4, 32'h00000000);
    add_row(OP_LOAD,    8'd4,   6'd5,  32'h16,       0, '0);
    add_row(OP_ENCODE,  8'd4,   6'd0,  32'h0,        0, '0);
    add_row(OP_UNKNOWN, 8'd4,   6'd63, 32'hFFFFFFFF, 0, '0);
    add_row(OP_FLUSH,   8'd0,   6'd0,  32'h0,        1, 32'h000000B0);

    foreach (stim_rows[i]) begin
      apply_item(stim_rows[i].op, stim_rows[i].sym, stim_rows[i].len, stim_rows[i].code,
                 stim_rows[i].typed_n, stim_rows[i].typed, 1'b0);
    end

    // Mostly encodes of loaded symbols, with loads, flushes and some unknown ops mixed in.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 40) % 3) == 1;
      r = $urandom_range(0, 99);
      sym = SYM_W'($urandom_range(0, 255));
      len = LEN_W'($urandom_range(0, 63));
      code = $urandom;
      if (r < 12) begin
        op = OP_LOAD;
        r = $urandom_range(0, 99);
        if (r < 10) len = 6'd0;
        else if (r < 20) len = LEN_W'($urandom_range(33, 63));
        else if (r < 35) len = LEN_W'($urandom_range(17, 32));
        else len = LEN_W'($urandom_range(1, 16));
      end else if (r < 20) begin
        op = OP_FLUSH;
      end else if (r < 23) begin
        op = OP_UNKNOWN;
      end else begin
        op = OP_ENCODE;
        sym = written_syms[$urandom_range(0, written_syms.size() - 1)];
      end
      apply_item(op, sym, len, code, FROM_PREDICTOR, '0, quiet);
    end
    in_if.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("huffman_bit_packer_core_tb passed");
    end else begin
      $display("huffman_bit_packer_core_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hbp_pkg.sv
hw/rtl/hbp_if.sv
hw/rtl/hbp_ram.sv
hw/rtl/hbp_ctrl.sv
hw/rtl/hbp_datapath.sv
hw/rtl/huffman_bit_packer_core.sv
dv/huffman_bit_packer_core_tb.sv
